[hdl/lps_pkg.sv]
// Shared types and Q16.16 arithmetic helpers for the LU pivoting linear solver.
package lps_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned FracW = 16;
    localparam int unsigned ProdW = 48;
    localparam int unsigned AccW = 56;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_INIT   = 15'b000000000000010,
        S_PSTART = 15'b000000000000100,
        S_PIV    = 15'b000000000001000,
        S_SWAP   = 15'b000000000010000,
        S_EROW   = 15'b000000000100000,
        S_EDIV   = 15'b000000001000000,
        S_EMUL   = 15'b000000010000000,
        S_EUPD   = 15'b000000100000000,
        S_FROW   = 15'b000001000000000,
        S_FMUL   = 15'b000010000000000,
        S_FACC   = 15'b000100000000000,
        S_BMUL   = 15'b001000000000000,
        S_BDIV   = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    // Product of two Q16.16 values, truncated toward zero.
    function automatic logic signed [ProdW-1:0] qmul(input logic signed [DataW-1:0] a,
                                                     input logic signed [DataW-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        if (p < 0) begin
            p = p + 64'sd65535;
        end
        return ProdW'(p >>> FracW);
    endfunction

    // Saturate to int32; the top bit of the result flags saturation.
    function automatic logic [DataW:0] clamp(input logic signed [63:0] v);
        logic [DataW:0] r;
        if (v > 64'sh7FFFFFFF) begin
            r = {1'b1, 32'h7FFFFFFF};
        end else if (v < -64'sh80000000) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, v[DataW-1:0]};
        end
        return r;
    endfunction

    function automatic logic [DataW:0] mag(input logic signed [DataW-1:0] a);
        logic signed [DataW:0] e;
        e = (DataW+1)'(a);
        return (a < 0) ? (DataW+1)'(-e) : (DataW+1)'(e);
    endfunction

endpackage

[hdl/lps_div.sv]
// Radix-2 restoring divider for Q16.16 quotients, one quotient bit per cycle.
module lps_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_num,
    input  logic signed [31:0]       i_den,
    output logic                     o_done,
    output logic signed [63:0]       o_quot
);
    localparam int unsigned QW = 48;

    logic [32:0]  r_rem;
    logic [QW-1:0] r_quo;
    logic [31:0]  r_den;
    logic         r_neg;
    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic [32:0]  n_trial;
    logic [32:0]  a_mag;
    logic [32:0]  b_mag;

    assign a_mag = lps_pkg::mag(i_num);
    assign b_mag = lps_pkg::mag(i_den);
    assign n_trial = {r_rem[31:0], r_quo[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {a_mag[31:0], 16'h0000};
            r_den <= b_mag[31:0];
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= n_trial - {1'b0, r_den};
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(64'(r_quo)) : $signed(64'(r_quo));
endmodule

[hdl/lu_pivot_linear_solver_core.sv]
// Top level of the LU pivoting linear solver: stores, sequencer and shared arithmetic.
// Load items are taken one per cycle while idle; the item carrying tlast starts a solve during
// which the input is not ready. A solve shares one product register and one bit-serial divider
// under a sequencer.
// The n results then leave one per accepted transfer, the last with tlast set.
module lu_pivot_linear_solver_core #(
    parameter int MAX_SIZE = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // row[1:0], col[3:2], value[35:4], zero fill
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // index[1:0], solution[33:2], zero fill
    output logic [1:0]  o_m_tuser,  // singular[0], saturated[1]
    output logic        o_m_tlast
);
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW = $clog2(MAX_SIZE + 1);

    lps_pkg::t_state r_state;
    logic signed [31:0] r_a [MAX_SIZE][MAX_SIZE];
    logic signed [31:0] r_u [MAX_SIZE][MAX_SIZE];
    logic signed [31:0] r_l [MAX_SIZE][MAX_SIZE];
    logic signed [31:0] r_b [MAX_SIZE];
    logic signed [31:0] r_w [MAX_SIZE];
    logic signed [31:0] r_x [MAX_SIZE];
    logic [1:0]    r_cfg;
    logic [NW-1:0] r_i, r_j, r_k, r_piv, r_oidx;
    logic [32:0]   r_best;
    logic signed [31:0] r_m;
    logic signed [47:0] r_prod;
    logic signed [55:0] r_acc;
    logic          r_sat, r_sing;

    logic [NW-1:0] n_size;
    logic          s_acc;
    logic [1:0]    in_row, in_col;
    logic          div_start, div_done;
    logic signed [31:0] div_num, div_den;
    logic signed [63:0] div_quot;
    logic [32:0]   div_cl;
    logic [32:0]   upd_cl, sub_cl;
    logic signed [31:0] sub_src;

    always_comb begin
        if (r_cfg == 2'd0) begin
            n_size = NW'(1);
        end else if (int'(r_cfg) > MAX_SIZE) begin
            n_size = NW'(MAX_SIZE);
        end else begin
            n_size = NW'(r_cfg);
        end
    end

    assign in_row = i_s_tdata[1:0];
    assign in_col = i_s_tdata[3:2];
    assign o_s_tready = (r_state == lps_pkg::S_IDLE);
    assign s_acc = i_s_tvalid && o_s_tready;

    // The divider serves both the multipliers and the back-substitution quotients.
    assign div_start = ((r_state == lps_pkg::S_EROW) && (r_i < n_size))
                    || ((r_state == lps_pkg::S_BMUL) && (r_j >= n_size));
    always_comb begin
        if (r_state == lps_pkg::S_EROW) begin
            div_num = r_u[IW'(r_i)][IW'(r_j)];
            div_den = r_u[IW'(r_j)][IW'(r_j)];
        end else begin
            div_num = sub_cl[31:0];
            div_den = r_u[IW'(r_i)][IW'(r_i)];
        end
    end

    lps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign div_cl = lps_pkg::clamp(div_quot);
    assign upd_cl = lps_pkg::clamp(64'(r_u[IW'(r_i)][IW'(r_k)]) - 64'(r_prod));
    assign sub_src = (r_state == lps_pkg::S_FMUL) ? r_b[IW'(r_i)] : r_w[IW'(r_i)];
    assign sub_cl = lps_pkg::clamp(64'(sub_src) - 64'(r_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lps_pkg::S_IDLE;
            r_cfg   <= 2'd3;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                lps_pkg::S_IDLE: begin
                    if (s_acc && i_s_tlast) r_state <= lps_pkg::S_INIT;
                end
                lps_pkg::S_INIT:   r_state <= lps_pkg::S_PSTART;
                lps_pkg::S_PSTART: r_state <= lps_pkg::S_PIV;
                lps_pkg::S_PIV: begin
                    if (r_i >= n_size) begin
                        if (r_best == '0) r_state <= lps_pkg::S_OUT;
                        else if (r_piv != r_j) r_state <= lps_pkg::S_SWAP;
                        else r_state <= lps_pkg::S_EROW;
                    end
                end
                lps_pkg::S_SWAP: r_state <= lps_pkg::S_EROW;
                lps_pkg::S_EROW: begin
                    if (r_i < n_size) r_state <= lps_pkg::S_EDIV;
                    else if (r_j + NW'(1) < n_size) r_state <= lps_pkg::S_PSTART;
                    else r_state <= lps_pkg::S_FROW;
                end
                lps_pkg::S_EDIV: begin
                    if (div_done) r_state <= lps_pkg::S_EMUL;
                end
                lps_pkg::S_EMUL: begin
                    r_state <= (r_k < n_size) ? lps_pkg::S_EUPD : lps_pkg::S_EROW;
                end
                lps_pkg::S_EUPD: r_state <= lps_pkg::S_EMUL;
                lps_pkg::S_FROW: begin
                    r_state <= (r_i < n_size) ? lps_pkg::S_FMUL : lps_pkg::S_BMUL;
                end
                lps_pkg::S_FMUL: begin
                    r_state <= (r_j < r_i) ? lps_pkg::S_FACC : lps_pkg::S_FROW;
                end
                lps_pkg::S_FACC: begin
                    r_state <= (r_k == '0) ? lps_pkg::S_FMUL : lps_pkg::S_BMUL;
                end
                lps_pkg::S_BMUL: begin
                    r_state <= (r_j < n_size) ? lps_pkg::S_FACC : lps_pkg::S_BDIV;
                end
                lps_pkg::S_BDIV: begin
                    if (div_done) r_state <= (r_i == '0) ? lps_pkg::S_OUT : lps_pkg::S_BMUL;
                end
                lps_pkg::S_OUT: begin
                    if (i_m_tready && (r_oidx == n_size - NW'(1))) r_state <= lps_pkg::S_IDLE;
                end
                default: r_state <= lps_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath; r_k doubles as a phase mark in the accumulate step (zero forward, one back).
    always_ff @(posedge i_clk) begin
        case (r_state)
            lps_pkg::S_IDLE: begin
                if (s_acc && (NW'(in_row) < n_size) && (int'(in_row) < MAX_SIZE)) begin
                    if (NW'(in_col) < n_size) begin
                        r_a[IW'(in_row)][IW'(in_col)] <= $signed(i_s_tdata[35:4]);
                    end else if (NW'(in_col) == n_size) begin
                        r_b[IW'(in_row)] <= $signed(i_s_tdata[35:4]);
                    end
                end
            end
            lps_pkg::S_INIT: begin
                for (int p = 0; p < MAX_SIZE; p++) begin
                    for (int q = 0; q < MAX_SIZE; q++) begin
                        r_u[p][q] <= r_a[p][q];
                        r_l[p][q] <= (p == q) ? 32'sh00010000 : 32'sh0;
                    end
                end
                r_sat  <= 1'b0;
                r_sing <= 1'b0;
                r_j    <= '0;
                r_oidx <= '0;
            end
            lps_pkg::S_PSTART: begin
                r_best <= lps_pkg::mag(r_u[IW'(r_j)][IW'(r_j)]);
                r_piv  <= r_j;
                r_i    <= r_j + NW'(1);
            end
            lps_pkg::S_PIV: begin
                if (r_i < n_size) begin
                    if (lps_pkg::mag(r_u[IW'(r_i)][IW'(r_j)]) > r_best) begin
                        r_best <= lps_pkg::mag(r_u[IW'(r_i)][IW'(r_j)]);
                        r_piv  <= r_i;
                    end
                    r_i <= r_i + NW'(1);
                end else begin
                    r_i <= r_j + NW'(1);
                    if (r_best == '0) r_sing <= 1'b1;
                end
            end
            lps_pkg::S_SWAP: begin
                // Row swap: U and b whole, A in active columns, L left of column j.
                for (int q = 0; q < MAX_SIZE; q++) begin
                    r_u[IW'(r_j)][q]   <= r_u[IW'(r_piv)][q];
                    r_u[IW'(r_piv)][q] <= r_u[IW'(r_j)][q];
                    if (q < int'(n_size)) begin
                        r_a[IW'(r_j)][q]   <= r_a[IW'(r_piv)][q];
                        r_a[IW'(r_piv)][q] <= r_a[IW'(r_j)][q];
                    end
                    if (q < int'(r_j)) begin
                        r_l[IW'(r_j)][q]   <= r_l[IW'(r_piv)][q];
                        r_l[IW'(r_piv)][q] <= r_l[IW'(r_j)][q];
                    end
                end
                r_b[IW'(r_j)]   <= r_b[IW'(r_piv)];
                r_b[IW'(r_piv)] <= r_b[IW'(r_j)];
            end
            lps_pkg::S_EROW: begin
                if (r_i >= n_size) begin
                    r_j <= r_j + NW'(1);
                    r_i <= '0;
                end
            end
            lps_pkg::S_EDIV: begin
                if (div_done) begin
                    r_m <= div_cl[31:0];
                    r_l[IW'(r_i)][IW'(r_j)] <= div_cl[31:0];
                    r_u[IW'(r_i)][IW'(r_j)] <= '0;
                    r_sat <= r_sat | div_cl[32];
                    r_k <= r_j + NW'(1);
                end
            end
            lps_pkg::S_EMUL: begin
                if (r_k < n_size) begin
                    r_prod <= lps_pkg::qmul(r_m, r_u[IW'(r_j)][IW'(r_k)]);
                end else begin
                    r_i <= r_i + NW'(1);
                end
            end
            lps_pkg::S_EUPD: begin
                r_u[IW'(r_i)][IW'(r_k)] <= upd_cl[31:0];
                r_sat <= r_sat | upd_cl[32];
                r_k <= r_k + NW'(1);
            end
            lps_pkg::S_FROW: begin
                r_acc <= '0;
                if (r_i >= n_size) begin
                    r_i <= n_size - NW'(1);
                    r_j <= n_size;
                    r_k <= NW'(1);
                end else begin
                    r_j <= '0;
                    r_k <= '0;
                end
            end
            lps_pkg::S_FMUL: begin
                if (r_j < r_i) begin
                    r_prod <= lps_pkg::qmul(r_l[IW'(r_i)][IW'(r_j)], r_w[IW'(r_j)]);
                end else begin
                    r_w[IW'(r_i)] <= sub_cl[31:0];
                    r_sat <= r_sat | sub_cl[32];
                    r_i <= r_i + NW'(1);
                end
            end
            lps_pkg::S_FACC: begin
                r_acc <= r_acc + 56'(r_prod);
                r_j   <= r_j + NW'(1);
            end
            lps_pkg::S_BMUL: begin
                if (r_j < n_size) begin
                    r_prod <= lps_pkg::qmul(r_u[IW'(r_i)][IW'(r_j)], r_x[IW'(r_j)]);
                end else begin
                    r_sat <= r_sat | sub_cl[32];
                end
            end
            lps_pkg::S_BDIV: begin
                if (div_done) begin
                    r_x[IW'(r_i)] <= div_cl[31:0];
                    r_sat <= r_sat | div_cl[32];
                    r_acc <= '0;
                    r_j   <= r_i;
                    r_i   <= r_i - NW'(1);
                end
            end
            lps_pkg::S_OUT: begin
                if (i_m_tready) r_oidx <= r_oidx + NW'(1);
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = (r_state == lps_pkg::S_OUT);
    assign o_m_tdata  = {6'd0, (r_sing ? 32'h0 : r_x[IW'(r_oidx)]), 2'(r_oidx)};
    assign o_m_tuser  = {r_sat, r_sing};
    assign o_m_tlast  = (r_oidx == n_size - NW'(1));

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[33:2] == 32'h0)
        else $error("singular result carries a nonzero solution");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while results pending");
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> o_s_tready)
        else $error("block did not return to idle after the last result");
    a_state_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");
endmodule
